// File: hw/rtl/pixel_format_to_rgba_converter_core_macros.svh
// assertion macros for the pixel format converter
// expects clk and rst_n in the scope where they are used
`ifndef PIXEL_FORMAT_TO_RGBA_CONVERTER_CORE_MACROS_SVH
`define PIXEL_FORMAT_TO_RGBA_CONVERTER_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
`define PFC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define PFC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PFC_ASSERT_SAME(label, ante, cons, msg)
`define PFC_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// File: hw/rtl/pfc_pkg.sv
// types, format codes and helper functions for the pixel format converter
// no dependencies
`timescale 1ns / 1ps

package pfc_pkg;

    localparam logic [2:0] FMT_RGBA8 = 3'd0;
    localparam logic [2:0] FMT_BGRA8 = 3'd1;
    localparam logic [2:0] FMT_RGB8  = 3'd2;
    localparam logic [2:0] FMT_YUYV  = 3'd3;
    localparam logic [2:0] FMT_NV12  = 3'd4;

    // bt.601 video range, q8
    localparam logic signed [10:0] K_LUMA   = 11'sd298;
    localparam logic signed [10:0] K_CR_R   = 11'sd409;
    localparam logic signed [10:0] K_CB_G   = 11'sd100;
    localparam logic signed [10:0] K_CR_G   = 11'sd208;
    localparam logic signed [10:0] K_CB_B   = 11'sd516;
    localparam logic signed [9:0]  Y_OFFSET = 10'sd16;
    localparam logic signed [9:0]  C_OFFSET = 10'sd128;
    localparam logic [7:0]         ALPHA_OPAQUE = 8'hFF;

    typedef struct packed {
        logic [7:0] byte_zero;
        logic [7:0] byte_one;
        logic [7:0] byte_two;
        logic [7:0] byte_three;
    } pix_in_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       last_pixel;
        logic       converted;
    } pix_out_t;

    // one classified request between front and back
    typedef struct packed {
        logic               is_yuv;
        logic               two_pix;
        logic               converted;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic [7:0]         alpha;
        logic signed [17:0] luma0;
        logic signed [17:0] luma1;
        logic signed [17:0] chroma_r;
        logic signed [17:0] chroma_g;
        logic signed [17:0] chroma_b;
    } pfc_cmd_t;

    function automatic logic signed [17:0] mul_k(logic signed [9:0] x,
                                                 logic signed [10:0] k);
        logic signed [17:0] xe;
        logic signed [17:0] ke;
        xe = 18'(x);
        ke = 18'(k);
        return xe * ke;
    endfunction

    // floor(v / 256) clamped to 0..255
    function automatic logic [7:0] clamp_q8(logic signed [19:0] v);
        logic [7:0] res;
        if (v[19])
            res = 8'd0;
        else if (|v[18:16])
            res = 8'hFF;
        else
            res = v[15:8];
        return res;
    endfunction

endpackage

// File: hw/rtl/pfc_front.sv
// front end: format register and classification of each input word
// depends on pfc_pkg
`timescale 1ns / 1ps

module pfc_front
    import pfc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [2:0] cfg_wdata,
    input  pix_in_t    src_pixel,
    output pfc_cmd_t   cmd
);

    logic [2:0]        format_reg;
    logic [2:0]        format_next;
    logic signed [9:0] c0;
    logic signed [9:0] c1;
    logic signed [9:0] d;
    logic signed [9:0] e;
    logic [7:0]        v_byte;

    assign format_next = cfg_we ? cfg_wdata : format_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            format_reg <= FMT_RGBA8;
        else
            format_reg <= format_next;
    end

    // nv12 carries v in the third byte, yuyv in the fourth
    assign v_byte = (format_reg == FMT_YUYV) ? src_pixel.byte_three : src_pixel.byte_two;

    assign c0 = $signed({2'b00, src_pixel.byte_zero}) - Y_OFFSET;
    assign c1 = $signed({2'b00, src_pixel.byte_two}) - Y_OFFSET;
    assign d  = $signed({2'b00, src_pixel.byte_one}) - C_OFFSET;
    assign e  = $signed({2'b00, v_byte}) - C_OFFSET;

    always_comb
    begin
        cmd.luma0    = mul_k(c0, K_LUMA);
        cmd.luma1    = mul_k(c1, K_LUMA);
        cmd.chroma_r = mul_k(e, K_CR_R);
        cmd.chroma_g = mul_k(d, K_CB_G) + mul_k(e, K_CR_G);
        cmd.chroma_b = mul_k(d, K_CB_B);
        cmd.is_yuv    = 1'b0;
        cmd.two_pix   = 1'b0;
        cmd.converted = 1'b1;
        cmd.red       = src_pixel.byte_zero;
        cmd.green     = src_pixel.byte_one;
        cmd.blue      = src_pixel.byte_two;
        cmd.alpha     = src_pixel.byte_three;
        unique case (format_reg)
            FMT_RGBA8: ;
            FMT_BGRA8:
            begin
                cmd.red  = src_pixel.byte_two;
                cmd.blue = src_pixel.byte_zero;
            end
            FMT_RGB8:
                cmd.alpha = ALPHA_OPAQUE;
            FMT_YUYV:
            begin
                cmd.is_yuv  = 1'b1;
                cmd.two_pix = 1'b1;
            end
            FMT_NV12:
                cmd.is_yuv = 1'b1;
            default:
                cmd.converted = 1'b0;
        endcase
    end

endmodule

// File: hw/rtl/pfc_queue.sv
// small request queue between front and back
// depends on pfc_pkg
`timescale 1ns / 1ps

module pfc_queue
    import pfc_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push_valid,
    output logic     push_ready,
    input  pfc_cmd_t push_cmd,
    output logic     pop_valid,
    input  logic     pop_ready,
    output pfc_cmd_t pop_cmd
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    pfc_cmd_t        entry_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg;
    logic [PW-1:0]   rd_ptr_next;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic            push;
    logic            pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

// File: hw/rtl/pfc_back.sv
// back end: yuv sums, floor and clamp, pixel sequencing and output register
// depends on pfc_pkg
`timescale 1ns / 1ps

module pfc_back
    import pfc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     pop_valid,
    output logic     pop_ready,
    input  pfc_cmd_t cmd,
    output logic     dst_valid,
    input  logic     dst_ready,
    output pix_out_t dst_pixel
);

    logic               pix_sel_reg;
    logic               pix_sel_next;
    logic               dst_valid_reg;
    logic               dst_valid_next;
    pix_out_t           dst_pixel_reg;
    pix_out_t           dst_pixel_next;
    logic               load_en;
    logic               fire;
    logic               is_last;
    logic signed [19:0] luma;
    logic signed [19:0] sum_r;
    logic signed [19:0] sum_g;
    logic signed [19:0] sum_b;

    assign load_en   = !dst_valid_reg || dst_ready;
    assign fire      = pop_valid && load_en;
    assign is_last   = !cmd.two_pix || pix_sel_reg;
    assign pop_ready = load_en && is_last;

    // second yuyv pixel uses y1
    assign luma  = pix_sel_reg ? 20'(cmd.luma1) : 20'(cmd.luma0);
    assign sum_r = luma + 20'(cmd.chroma_r);
    assign sum_g = luma - 20'(cmd.chroma_g);
    assign sum_b = luma + 20'(cmd.chroma_b);

    always_comb
    begin
        dst_pixel_next.last_pixel = is_last;
        dst_pixel_next.converted  = cmd.converted;
        if (cmd.is_yuv)
        begin
            dst_pixel_next.red   = clamp_q8(sum_r);
            dst_pixel_next.green = clamp_q8(sum_g);
            dst_pixel_next.blue  = clamp_q8(sum_b);
            dst_pixel_next.alpha = ALPHA_OPAQUE;
        end
        else
        begin
            dst_pixel_next.red   = cmd.red;
            dst_pixel_next.green = cmd.green;
            dst_pixel_next.blue  = cmd.blue;
            dst_pixel_next.alpha = cmd.alpha;
        end
    end

    always_comb
    begin
        pix_sel_next   = pix_sel_reg;
        dst_valid_next = dst_valid_reg;
        if (fire)
            pix_sel_next = cmd.two_pix && !pix_sel_reg;
        if (load_en)
            dst_valid_next = pop_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_sel_reg   <= 1'b0;
            dst_valid_reg <= 1'b0;
        end
        else
        begin
            pix_sel_reg   <= pix_sel_next;
            dst_valid_reg <= dst_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
            dst_pixel_reg <= dst_pixel_next;
    end

    assign dst_valid = dst_valid_reg;
    assign dst_pixel = dst_pixel_reg;

endmodule

// File: hw/rtl/pixel_format_to_rgba_converter_core.sv
// top level of the pixel format to rgba8 converter
// depends on pfc_pkg, pfc_front, pfc_queue, pfc_back and the macros header
//
//   channel   signals                        width   direction
//   src       src_valid src_ready src_pixel  32      in
//   dst       dst_valid dst_ready dst_pixel  34      out
//   cfg       cfg_we cfg_wdata               3       in
//
// one output pixel per cycle while dst is ready; a yuyv word gives two pixels, every other format one
// an accepted word passes the queue, then the output register, before its first pixel shows at dst
// the output register pairs with the queue so src keeps accepting while dst stalls, until the queue fills
// reset clears the queue, the pixel sequencer and the format register to rgba8
`timescale 1ns / 1ps

`include "pixel_format_to_rgba_converter_core_macros.svh"

module pixel_format_to_rgba_converter_core
    import pfc_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [2:0] cfg_wdata,
    input  logic       src_valid,
    output logic       src_ready,
    input  pix_in_t    src_pixel,
    output logic       dst_valid,
    input  logic       dst_ready,
    output pix_out_t   dst_pixel
);

    pfc_cmd_t front_cmd;
    pfc_cmd_t head_cmd;
    logic     head_valid;
    logic     head_ready;

    pfc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .src_pixel (src_pixel),
        .cmd       (front_cmd)
    );

    pfc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (src_valid),
        .push_ready (src_ready),
        .push_cmd   (front_cmd),
        .pop_valid  (head_valid),
        .pop_ready  (head_ready),
        .pop_cmd    (head_cmd)
    );

    pfc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (head_valid),
        .pop_ready (head_ready),
        .cmd       (head_cmd),
        .dst_valid (dst_valid),
        .dst_ready (dst_ready),
        .dst_pixel (dst_pixel)
    );

    // a first pixel of a pair is always a converted opaque yuv pixel
    `PFC_ASSERT_SAME(a_first_pixel_yuv, dst_valid && !dst_pixel.last_pixel, dst_pixel.converted && dst_pixel.alpha == ALPHA_OPAQUE, "first of pair not a yuv pixel")
    // unsupported formats give exactly one pixel
    `PFC_ASSERT_SAME(a_raw_single, dst_valid && !dst_pixel.converted, dst_pixel.last_pixel, "raw pixel not marked last")
    // the second pixel follows right after the first is taken
    `PFC_ASSERT_NEXT(a_pair_follows, dst_valid && dst_ready && !dst_pixel.last_pixel, dst_valid && dst_pixel.last_pixel, "second pixel of pair missing")
    // the queue head is released only on the last pixel of its request
    `PFC_ASSERT_SAME(a_pop_on_last, head_valid && head_ready, !head_cmd.two_pix || (dst_valid && !dst_pixel.last_pixel), "request popped before its last pixel")

endmodule

// File: tb/pixel_format_to_rgba_converter_core_test.sv
// self-checking testbench for pixel_format_to_rgba_converter_core
// depends on pfc_pkg and the core rtl; predicts rgba8 pixels per source format
`timescale 1ns / 1ps

module pixel_format_to_rgba_converter_core_test;
    import pfc_pkg::*;

    // codes with no conversion path, bytes go out unchanged
    localparam logic [2:0] FMT_MJPEG   = 3'd5;
    localparam logic [2:0] FMT_SPARE_6 = 3'd6;
    localparam logic [2:0] FMT_SPARE_7 = 3'd7;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       cfg_we    = 1'b0;
    logic [2:0] cfg_wdata = FMT_RGBA8;
    logic       src_valid = 1'b0;
    logic       src_ready;
    pix_in_t    src_pixel = '0;
    logic       dst_valid;
    logic       dst_ready = 1'b0;
    pix_out_t   dst_pixel;

    pix_out_t   expected_pixels[$];
    logic [2:0] format_shadow = FMT_RGBA8;
    int         error_count   = 0;
    int         idle_cycles   = 0;
    int         stall_left    = 0;
    bit         src_idle_on   = 1'b1;
    bit         dst_idle_on   = 1'b1;

    pixel_format_to_rgba_converter_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .src_valid (src_valid),
        .src_ready (src_ready),
        .src_pixel (src_pixel),
        .dst_valid (dst_valid),
        .dst_ready (dst_ready),
        .dst_pixel (dst_pixel)
    );

    always #4 clk = ~clk;

    task automatic report_failure(input string msg);
        $display("error at %0t: %s", $time, msg);
        error_count++;
    endtask

    // floor of q8 value, then saturate to a byte
    function automatic logic [7:0] sat_q8(input int v);
        int q;
        q = v >>> 8;
        if (q < 0)
            return 8'd0;
        if (q > 255)
            return 8'hFF;
        return q[7:0];
    endfunction

    function automatic pix_out_t yuv_to_rgba(input logic [7:0] y, input logic [7:0] u,
                                             input logic [7:0] v, input logic last);
        int       c;
        int       d;
        int       e;
        pix_out_t p;
        c = int'(y) - 16;
        d = int'(u) - 128;
        e = int'(v) - 128;
        p.red        = sat_q8(298 * c + 409 * e);
        p.green      = sat_q8(298 * c - 100 * d - 208 * e);
        p.blue       = sat_q8(298 * c + 516 * d);
        p.alpha      = ALPHA_OPAQUE;
        p.last_pixel = last;
        p.converted  = 1'b1;
        return p;
    endfunction

    function automatic pix_out_t plain_pixel(input logic [7:0] r, input logic [7:0] g,
                                             input logic [7:0] b, input logic [7:0] a,
                                             input logic conv);
        pix_out_t p;
        p.red        = r;
        p.green      = g;
        p.blue       = b;
        p.alpha      = a;
        p.last_pixel = 1'b1;
        p.converted  = conv;
        return p;
    endfunction

    // append one predicted pixel at the tail of the expected queue
    function automatic void add_expected(input pix_out_t p);
        expected_pixels = {expected_pixels, p};
    endfunction

    function automatic void predict_word(input logic [2:0] fmt, input pix_in_t w);
        case (fmt)
            FMT_RGBA8:
                add_expected(plain_pixel(w.byte_zero, w.byte_one, w.byte_two,
                                         w.byte_three, 1'b1));
            FMT_BGRA8:
                add_expected(plain_pixel(w.byte_two, w.byte_one, w.byte_zero,
                                         w.byte_three, 1'b1));
            FMT_RGB8:
                add_expected(plain_pixel(w.byte_zero, w.byte_one, w.byte_two,
                                         ALPHA_OPAQUE, 1'b1));
            FMT_YUYV:
            begin
                add_expected(yuv_to_rgba(w.byte_zero, w.byte_one,
                                         w.byte_three, 1'b0));
                add_expected(yuv_to_rgba(w.byte_two, w.byte_one,
                                         w.byte_three, 1'b1));
            end
            FMT_NV12:
                add_expected(yuv_to_rgba(w.byte_zero, w.byte_one,
                                         w.byte_two, 1'b1));
            default:
                add_expected(plain_pixel(w.byte_zero, w.byte_one, w.byte_two,
                                         w.byte_three, 1'b0));
        endcase
    endfunction

    task automatic check_pixel(input pix_out_t got, input pix_out_t want);
        if (got.red !== want.red)
            report_failure($sformatf("red got %0h want %0h", got.red, want.red));
        if (got.green !== want.green)
            report_failure($sformatf("green got %0h want %0h", got.green, want.green));
        if (got.blue !== want.blue)
            report_failure($sformatf("blue got %0h want %0h", got.blue, want.blue));
        if (got.alpha !== want.alpha)
            report_failure($sformatf("alpha got %0h want %0h", got.alpha, want.alpha));
        if (got.last_pixel !== want.last_pixel)
            report_failure($sformatf("last_pixel got %b want %b",
                                     got.last_pixel, want.last_pixel));
        if (got.converted !== want.converted)
            report_failure($sformatf("converted got %b want %b",
                                     got.converted, want.converted));
    endtask

    // results are checked before this edge's request is predicted
    always @(posedge clk)
    begin : pixel_monitor
        pix_out_t want;
        if (rst_n)
        begin
            if (dst_valid && dst_ready)
            begin
                if (expected_pixels.size() == 0)
                    report_failure($sformatf("unexpected pixel %0h", dst_pixel));
                else
                begin
                    want = expected_pixels.pop_front();
                    check_pixel(dst_pixel, want);
                end
            end
            if (src_valid && src_ready)
                predict_word(format_shadow, src_pixel);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((src_valid && src_ready) || (dst_valid && dst_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // receiver back-pressure in bursts
    always @(negedge clk)
    begin
        if (stall_left == 0 && dst_idle_on && $urandom_range(0, 5) == 0)
            stall_left = $urandom_range(1, 15);
        if (stall_left > 0)
        begin
            dst_ready <= 1'b0;
            stall_left--;
        end
        else
            dst_ready <= 1'b1;
    end

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'd16;
            3: return 8'd235;
            4: return 8'd128;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic send_word(input pix_in_t w);
        int gap;
        gap = (src_idle_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 15) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            src_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        src_valid <= 1'b1;
        src_pixel <= w;
        forever
        begin
            @(posedge clk);
            if (src_ready)
                break;
        end
    endtask

    // format changes only once every pending pixel is out
    task automatic set_source_format(input logic [2:0] fmt);
        @(negedge clk);
        src_valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= fmt;
        @(posedge clk);
        format_shadow = fmt;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic test_directed_patterns();
        logic [2:0] all_formats[8];
        all_formats = '{FMT_RGBA8, FMT_BGRA8, FMT_RGB8, FMT_YUYV, FMT_NV12,
                        FMT_MJPEG, FMT_SPARE_6, FMT_SPARE_7};
        foreach (all_formats[i])
        begin
            set_source_format(all_formats[i]);
            send_word(32'h0000_0000);
            send_word(32'hFFFF_FFFF);
            if (all_formats[i] == FMT_BGRA8 || all_formats[i] == FMT_RGB8)
                send_word(32'h0102_0304);
            // black, white and both clamp directions
            if (all_formats[i] == FMT_YUYV)
            begin
                send_word({8'd16, 8'd128, 8'd235, 8'd128});
                send_word({8'd0, 8'd0, 8'd255, 8'd255});
                send_word({8'd255, 8'd255, 8'd0, 8'd0});
            end
            // last one floors a small negative sum
            if (all_formats[i] == FMT_NV12)
            begin
                send_word({8'd16, 8'd128, 8'd128, 8'hA5});
                send_word({8'd235, 8'd0, 8'd255, 8'h5A});
                send_word({8'd17, 8'd128, 8'd127, 8'h00});
            end
        end
    endtask

    task automatic test_random_phases();
        logic [2:0] phase_formats[10];
        phase_formats = '{FMT_YUYV, FMT_NV12, FMT_RGBA8, FMT_BGRA8, FMT_RGB8,
                          FMT_SPARE_7, FMT_YUYV, FMT_MJPEG, FMT_NV12, FMT_SPARE_6};
        foreach (phase_formats[p])
        begin
            set_source_format(phase_formats[p]);
            repeat (60)
                send_word({pick_byte(), pick_byte(), pick_byte(), pick_byte()});
        end
    endtask

    task automatic test_streaming_no_idle();
        src_idle_on = 1'b0;
        dst_idle_on = 1'b0;
        set_source_format(FMT_YUYV);
        repeat (60)
            send_word({pick_byte(), pick_byte(), pick_byte(), pick_byte()});
        set_source_format(FMT_RGBA8);
        repeat (40)
            send_word({pick_byte(), pick_byte(), pick_byte(), pick_byte()});
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_directed_patterns();
        test_random_phases();
        test_streaming_no_idle();
        @(negedge clk);
        src_valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
